// ----- hw/rtl/encoder_position_reversal_debounce_top_assert.svh -----
// Assertion macros used by the port-level checker of the encoder position debouncer.
`ifndef ENCODER_POSITION_REVERSAL_DEBOUNCE_TOP_ASSERT_SVH
`define ENCODER_POSITION_REVERSAL_DEBOUNCE_TOP_ASSERT_SVH

// Plain property check on the rising clock edge, disabled while reset is asserted.
`define EPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Overlapping implication: whenever pre holds, post must hold in the same cycle.
`define EPR_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

// ----- hw/rtl/epr_pkg.sv -----
// Package with types and constants of the encoder position debouncer.
package epr_pkg;

  localparam int unsigned PosW  = 32;
  localparam int unsigned CntW  = 8;
  localparam int unsigned NarW  = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic signed [PosW-1:0] MinPosReset = 32'sh8000_0000;
  localparam logic signed [PosW-1:0] MaxPosReset = 32'sh7FFF_FFFF;
  localparam logic [CntW-1:0]        CntMax      = 8'hFF;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MIN_POS   = 2'd0,
    REG_MAX_POS   = 2'd1,
    REG_THRESHOLD = 2'd2,
    REG_NARROW    = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_PRESET = 1'b1
  } action_e;

  typedef struct packed {
    logic                   action;
    logic [PosW-1:0]        raw_count;
    logic signed [PosW-1:0] preset_value;
  } in_t;

  typedef struct packed {
    logic signed [PosW-1:0] position;
    logic [1:0]             direction;
    logic                   reversal_pending;
  } out_t;

  typedef struct packed {
    logic signed [PosW-1:0] min_position;
    logic signed [PosW-1:0] max_position;
    logic [CntW-1:0]        debounce_threshold;
    logic                   narrow_counter;
  } cfg_t;

  // Clamped value waiting in the input register.
  typedef struct packed {
    logic                   preset;
    logic signed [PosW-1:0] value;
  } stg_t;

endpackage

// ----- hw/rtl/epr_cfg.sv -----
// Configuration registers of the encoder position debouncer.
module epr_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [epr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [epr_pkg::PosW-1:0]    cfg_wdata_i,
  output epr_pkg::cfg_t               cfg_o
);

  epr_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (epr_pkg::cfg_idx_e'(cfg_idx_i))
        epr_pkg::REG_MIN_POS:   cfg_d.min_position = $signed(cfg_wdata_i);
        epr_pkg::REG_MAX_POS:   cfg_d.max_position = $signed(cfg_wdata_i);
        epr_pkg::REG_THRESHOLD: cfg_d.debounce_threshold = cfg_wdata_i[epr_pkg::CntW-1:0];
        epr_pkg::REG_NARROW:    cfg_d.narrow_counter = cfg_wdata_i[0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_position       <= epr_pkg::MinPosReset;
      cfg_q.max_position       <= epr_pkg::MaxPosReset;
      cfg_q.debounce_threshold <= '0;
      cfg_q.narrow_counter     <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/epr_front.sv -----
// Input register with sign extension and clamping of the incoming value.
module epr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  epr_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  epr_pkg::in_t  in_i,
  input  logic          adv_i,
  output logic          stg_valid_o,
  output epr_pkg::stg_t stg_o
);

  logic                           stg_vld_q, stg_vld_d;
  epr_pkg::stg_t                  stg_q;
  logic                           accept;
  logic signed [epr_pkg::PosW-1:0] ext_val, raw_val, clamped;

  // The user must change limits and narrow mode only while idle (not enforced here), so the clamp can run on entry.
  always_comb begin
    if (cfg_i.narrow_counter) begin
      ext_val = $signed({{(epr_pkg::PosW-epr_pkg::NarW){in_i.raw_count[epr_pkg::NarW-1]}},
                         in_i.raw_count[epr_pkg::NarW-1:0]});
    end else begin
      ext_val = $signed(in_i.raw_count);
    end
    raw_val = (in_i.action == epr_pkg::ACT_PRESET) ? in_i.preset_value : ext_val;
    // The minimum test goes first, which decides the case of crossed limits.
    priority if (raw_val < cfg_i.min_position) begin
      clamped = cfg_i.min_position;
    end else if (raw_val > cfg_i.max_position) begin
      clamped = cfg_i.max_position;
    end else begin
      clamped = raw_val;
    end
  end

  assign in_stall_o = stg_vld_q && !adv_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    stg_vld_d = stg_vld_q;
    if (accept) begin
      stg_vld_d = 1'b1;
    end else if (adv_i) begin
      stg_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
    end else begin
      stg_vld_q <= stg_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_q.preset <= (in_i.action == epr_pkg::ACT_PRESET);
      stg_q.value  <= clamped;
    end
  end

  assign stg_valid_o = stg_vld_q;
  assign stg_o       = stg_q;

endmodule

// ----- hw/rtl/epr_track.sv -----
// Direction tracking state, reversal debounce and the result register.
module epr_track (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  epr_pkg::cfg_t cfg_i,
  input  logic          stg_valid_i,
  input  epr_pkg::stg_t stg_i,
  output logic          adv_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output epr_pkg::out_t out_o
);

  logic signed [epr_pkg::PosW-1:0] rep_q, rep_d, last_q, last_d;
  epr_pkg::dir_e                   conf_q, conf_d, pend_q, pend_d;
  logic [epr_pkg::CntW-1:0]        cnt_q, cnt_d;
  logic                            out_vld_q, out_vld_d;
  epr_pkg::out_t                   out_q;

  logic signed [epr_pkg::PosW:0]   delta;
  logic [epr_pkg::PosW:0]          mag;
  logic [epr_pkg::CntW-1:0]        mag_sat, base, cnt_sum;
  logic [epr_pkg::CntW:0]          sum_wide;
  epr_pkg::dir_e                   dir;

  assign adv_o = stg_valid_i && (!out_vld_q || !out_stall_i);

  // The difference is one bit wider than a position, so it never wraps.
  assign delta    = $signed({stg_i.value[epr_pkg::PosW-1], stg_i.value})
                  - $signed({last_q[epr_pkg::PosW-1], last_q});
  assign mag      = delta[epr_pkg::PosW] ? $unsigned(-delta) : $unsigned(delta);
  assign mag_sat  = (|mag[epr_pkg::PosW:epr_pkg::CntW]) ? epr_pkg::CntMax
                                                        : mag[epr_pkg::CntW-1:0];
  assign dir      = delta[epr_pkg::PosW] ? epr_pkg::DIR_DOWN : epr_pkg::DIR_UP;
  assign base     = (pend_q != dir) ? '0 : cnt_q;
  assign sum_wide = {1'b0, base} + {1'b0, mag_sat};
  assign cnt_sum  = sum_wide[epr_pkg::CntW] ? epr_pkg::CntMax : sum_wide[epr_pkg::CntW-1:0];

  always_comb begin
    rep_d  = rep_q;
    last_d = last_q;
    conf_d = conf_q;
    pend_d = pend_q;
    cnt_d  = cnt_q;
    if (adv_o) begin
      priority if (stg_i.preset || cfg_i.debounce_threshold == '0) begin
        rep_d  = stg_i.value;
        last_d = stg_i.value;
        conf_d = epr_pkg::DIR_NONE;
        pend_d = epr_pkg::DIR_NONE;
        cnt_d  = '0;
      end else if (delta != '0) begin
        last_d = stg_i.value;
        if (conf_q == epr_pkg::DIR_NONE || dir == conf_q) begin
          conf_d = dir;
          pend_d = epr_pkg::DIR_NONE;
          cnt_d  = '0;
          rep_d  = stg_i.value;
        end else if (cnt_sum >= cfg_i.debounce_threshold) begin
          // Enough travel in the new direction: the reversal is confirmed.
          conf_d = dir;
          pend_d = epr_pkg::DIR_NONE;
          cnt_d  = '0;
          rep_d  = stg_i.value;
        end else begin
          pend_d = dir;
          cnt_d  = cnt_sum;
        end
      end
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (adv_o) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_q     <= '0;
      last_q    <= '0;
      conf_q    <= epr_pkg::DIR_NONE;
      pend_q    <= epr_pkg::DIR_NONE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      rep_q     <= rep_d;
      last_q    <= last_d;
      conf_q    <= conf_d;
      pend_q    <= pend_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      out_q.position         <= rep_d;
      out_q.direction        <= conf_d;
      out_q.reversal_pending <= (pend_d != epr_pkg::DIR_NONE);
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

endmodule

// ----- hw/rtl/encoder_position_reversal_debounce_top.sv -----
// Top level of the encoder position debouncer with reversal confirmation.
//
//   Channel  Signals                          Direction  Payload
//   in       in_valid_i / in_stall_o / in_i   into block epr_pkg::in_t
//   out      out_valid_o / out_stall_i / out_o out of    epr_pkg::out_t
//   cfg      cfg_we_i / cfg_idx_i / cfg_wdata_i into block 32-bit write data
//
// One transaction per clock is sustained while out_stall_i is low; an accepted input passes
// through the input register, then the tracking update into the result register. The
// tracking update is the per-cycle loop. Reset clears the state and valid flags and sets
// the limits to their full range. A stalled output holds its result while the input
// register still takes one more transaction.
module encoder_position_reversal_debounce_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [epr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [epr_pkg::PosW-1:0]    cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  epr_pkg::in_t                in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output epr_pkg::out_t               out_o
);

  epr_pkg::cfg_t cfg;
  epr_pkg::stg_t stg;
  logic          stg_valid;
  logic          adv;

  epr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  epr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .adv_i       (adv),
    .stg_valid_o (stg_valid),
    .stg_o       (stg)
  );

  epr_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .stg_valid_i (stg_valid),
    .stg_i       (stg),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

// ----- hw/rtl/epr_checker.sv -----
// Port-level checker of the encoder position debouncer and its bind statement.
`include "encoder_position_reversal_debounce_top_assert.svh"

module epr_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input epr_pkg::out_t out_o
);

  logic pend_shown;
  logic dir_known;
  logic out_held;

  assign pend_shown = out_valid_o && out_o.reversal_pending;
  assign dir_known  = (out_o.direction != epr_pkg::DIR_NONE);
  assign out_held   = out_valid_o && out_stall_i;

  // A reversal can only be pending against an already confirmed direction.
  `EPR_ASSERT_IMP(a_pending_has_dir, pend_shown, dir_known, "pending reversal without direction")

  // The input side only backs up when the result register is blocked.
  `EPR_ASSERT_IMP(a_stall_only_when_full, in_stall_o, out_held, "input stalled while output free")

  `EPR_ASSERT(a_out_hold, out_held |=> out_valid_o && $stable(out_o), "stalled result changed")

endmodule

bind encoder_position_reversal_debounce_top epr_checker u_epr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_o       (out_o)
);
